/* rtl/core/mcfb_pkg.sv */
// Package for the motion command frame builder.
// Holds frame constants, the internal byte beat type and the CRC16 byte update.
// No dependencies.
package mcfb_pkg;

    localparam logic [7:0]  FRAME_HDR    = 8'hA5;
    localparam logic [7:0]  CMD_ATTITUDE = 8'h18;
    localparam logic [7:0]  CMD_RESET    = 8'h77;
    localparam logic [15:0] CRC_INIT     = 16'hFFFF;
    localparam logic [15:0] CRC_POLY     = 16'hA001;

    localparam logic REQ_ATTITUDE = 1'b0;
    localparam logic REQ_RESET    = 1'b1;

    localparam int ATT_LEN   = 17;
    localparam int RST_LEN   = 8;
    localparam int IDX_W     = $clog2(ATT_LEN);
    localparam int SPEED_POS = 14;
    localparam int WORD_POS  = 2;
    localparam int NUM_WBYTE = 12;
    localparam int WSEL_W    = $clog2(NUM_WBYTE);

    typedef enum logic [1:0] {
        BEAT_DATA   = 2'd0,
        BEAT_CRC_LO = 2'd1,
        BEAT_CRC_HI = 2'd2
    } t_beat_kind;

    typedef struct packed {
        logic [7:0] data;
        t_beat_kind kind;
        logic       last;
    } t_beat;

    // CRC16-MODBUS, reflected, one byte
    function automatic logic [15:0] crc_byte(input logic [15:0] crc_in, input logic [7:0] b);
        logic [15:0] c;
        c = crc_in ^ {8'h00, b};
        for (int k = 0; k < 8; k++) begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

endpackage

/* rtl/core/mcfb_if.sv */
// Channel interfaces: request channel and frame byte channel.
// Valid/ready handshake with payload. No dependencies.
interface mcfb_req_if;
    logic        valid;
    logic        ready;
    logic        req_type;
    logic [31:0] z_height_bits;
    logic [31:0] x_rot_bits;
    logic [31:0] y_rot_bits;
    logic [7:0]  speed_level;

    modport source (output valid, req_type, z_height_bits, x_rot_bits, y_rot_bits,
                    speed_level, input ready);
    modport sink   (input valid, req_type, z_height_bits, x_rot_bits, y_rot_bits,
                    speed_level, output ready);
endinterface

interface mcfb_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       last_byte;

    modport source (output valid, out_byte, last_byte, input ready);
    modport sink   (input valid, out_byte, last_byte, output ready);
endinterface

/* rtl/core/motion_command_frame_builder_top.sv */
// Channel   | Dir | Payload                                          | Transaction
// i_req     | in  | req_type, z/x/y float bits, speed_level          | one frame request
// o_frm     | out | out_byte, last_byte                              | one frame byte
//
// Emits one byte per cycle while o_frm.ready holds: 17 bytes per attitude frame,
// 8 per reset frame. After acceptance the first byte passes through the sequencer,
// CRC and output registers. The next request is taken in the cycle the previous
// frame's last byte leaves the sequencer, so frames run gap-free.
// Synchronous active-low reset clears valids and sets the running CRC to CRC_INIT.
// Back-pressure stalls each stage in place; nothing is dropped or repeated.
// Top level of the frame builder. Uses mcfb_pkg, mcfb_if, mcfb_serial, mcfb_crc, mcfb_out.
module motion_command_frame_builder_top
    import mcfb_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    mcfb_req_if.sink    i_req,
    mcfb_byte_if.source o_frm
);

    logic  w_s1_valid;
    logic  w_s1_ready;
    t_beat w_s1_beat;
    logic  w_s2_valid;
    logic  w_s2_ready;
    t_beat w_s2_beat;

    mcfb_serial u_serial (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_req        (i_req),
        .o_beat_valid (w_s1_valid),
        .o_beat       (w_s1_beat),
        .i_beat_ready (w_s1_ready)
    );

    mcfb_crc u_crc (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_beat_valid (w_s1_valid),
        .i_beat       (w_s1_beat),
        .o_beat_ready (w_s1_ready),
        .o_beat_valid (w_s2_valid),
        .o_beat       (w_s2_beat),
        .i_beat_ready (w_s2_ready)
    );

    mcfb_out u_out (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_beat_valid (w_s2_valid),
        .i_beat       (w_s2_beat),
        .o_beat_ready (w_s2_ready),
        .o_frm        (o_frm)
    );

endmodule

/* rtl/core/mcfb_serial.sv */
// Stage 1: request register and byte sequencer.
// Uses mcfb_pkg and mcfb_req_if; emits one beat per cycle while i_beat_ready is high, with CRC slots tagged.
module mcfb_serial
    import mcfb_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    mcfb_req_if.sink   i_req,
    output logic       o_beat_valid,
    output t_beat      o_beat,
    input  logic       i_beat_ready
);

    logic                  r_busy;
    logic [IDX_W-1:0]      r_idx;
    logic                  r_type;
    logic [NUM_WBYTE-1:0][7:0] r_words;
    logic [7:0]            r_speed;

    logic                  w_fire;
    logic                  w_done;
    logic                  w_accept;
    logic [IDX_W-1:0]      w_last_idx;
    logic [WSEL_W-1:0]     w_wsel;
    logic [IDX_W-1:0]      w_off;

    assign w_last_idx = (r_type == REQ_RESET) ? IDX_W'(RST_LEN - 1) : IDX_W'(ATT_LEN - 1);
    assign w_off      = r_idx - IDX_W'(WORD_POS);
    assign w_wsel     = w_off[WSEL_W-1:0];

    assign w_fire   = r_busy & i_beat_ready;
    assign w_done   = w_fire & o_beat.last;
    assign i_req.ready = ~r_busy | w_done;
    assign w_accept = i_req.valid & i_req.ready;
    assign o_beat_valid = r_busy;

    always_comb begin
        o_beat.data = 8'h00;
        o_beat.kind = BEAT_DATA;
        o_beat.last = 1'b0;
        priority if (r_idx == IDX_W'(0)) begin
            o_beat.data = FRAME_HDR;
        end else if (r_idx == IDX_W'(1)) begin
            o_beat.data = (r_type == REQ_RESET) ? CMD_RESET : CMD_ATTITUDE;
        end else if (r_idx == w_last_idx) begin
            o_beat.kind = BEAT_CRC_HI;
            o_beat.last = 1'b1;
        end else if (r_idx == w_last_idx - IDX_W'(1)) begin
            o_beat.kind = BEAT_CRC_LO;
        end else if (r_idx == IDX_W'(SPEED_POS)) begin
            o_beat.data = r_speed;
        end else begin
            o_beat.data = r_words[w_wsel];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_idx  <= '0;
        end else if (w_accept) begin
            r_busy <= 1'b1;
            r_idx  <= '0;
        end else if (w_done) begin
            r_busy <= 1'b0;
        end else if (w_fire) begin
            r_idx  <= r_idx + IDX_W'(1);
        end
    end

    // payload; reset requests carry zeros in the word bytes
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_type  <= i_req.req_type;
            r_speed <= i_req.speed_level;
            if (i_req.req_type == REQ_RESET) begin
                r_words <= '0;
            end else begin
                r_words <= {i_req.y_rot_bits, i_req.x_rot_bits, i_req.z_height_bits};
            end
        end
    end

endmodule

/* rtl/core/mcfb_crc.sv */
// Stage 2: running CRC16-MODBUS and substitution of the CRC slots.
// Uses mcfb_pkg; sits between mcfb_serial and mcfb_out.
module mcfb_crc
    import mcfb_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_beat_valid,
    input  t_beat i_beat,
    output logic  o_beat_ready,
    output logic  o_beat_valid,
    output t_beat o_beat,
    input  logic  i_beat_ready
);

    logic        r_vld;
    t_beat       r_beat;
    logic [15:0] r_crc;
    logic        w_fire;
    logic [7:0]  w_data;

    assign o_beat_ready = ~r_vld | i_beat_ready;
    assign w_fire       = i_beat_valid & o_beat_ready;
    assign o_beat_valid = r_vld;
    assign o_beat       = r_beat;

    always_comb begin
        unique case (i_beat.kind)
            BEAT_DATA:   w_data = i_beat.data;
            BEAT_CRC_LO: w_data = r_crc[7:0];
            BEAT_CRC_HI: w_data = r_crc[15:8];
            default:     w_data = i_beat.data;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
            r_crc <= CRC_INIT;
        end else begin
            if (o_beat_ready) begin
                r_vld <= i_beat_valid;
            end
            if (w_fire) begin
                unique case (i_beat.kind)
                    BEAT_DATA:   r_crc <= crc_byte(r_crc, i_beat.data);
                    BEAT_CRC_LO: r_crc <= r_crc;
                    BEAT_CRC_HI: r_crc <= CRC_INIT;
                    default:     r_crc <= r_crc;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fire) begin
            r_beat.data <= w_data;
            r_beat.kind <= i_beat.kind;
            r_beat.last <= i_beat.last;
        end
    end

endmodule

/* rtl/core/mcfb_out.sv */
// Stage 3: output register driving the frame byte channel.
// Uses mcfb_pkg and mcfb_byte_if.
module mcfb_out
    import mcfb_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_beat_valid,
    input  t_beat       i_beat,
    output logic        o_beat_ready,
    mcfb_byte_if.source o_frm
);

    logic       r_vld;
    logic [7:0] r_byte;
    logic       r_last;
    logic       w_fire;

    assign o_beat_ready = ~r_vld | o_frm.ready;
    assign w_fire       = i_beat_valid & o_beat_ready;

    assign o_frm.valid     = r_vld;
    assign o_frm.out_byte  = r_byte;
    assign o_frm.last_byte = r_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (o_beat_ready) begin
            r_vld <= i_beat_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fire) begin
            r_byte <= i_beat.data;
            r_last <= i_beat.last;
        end
    end

endmodule

/* rtl/core/mcfb_chk.sv */
// Port-level checker for the frame builder, bound to the top level.
// Uses mcfb_pkg; tracks byte position within the current frame.
module mcfb_chk
    import mcfb_pkg::*;
(
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_out_valid,
    input logic       i_out_ready,
    input logic [7:0] i_out_byte,
    input logic       i_out_last
);

    logic [IDX_W-1:0] r_pos;
    logic             w_fire;

    assign w_fire = i_out_valid & i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos <= '0;
        end else if (w_fire) begin
            r_pos <= i_out_last ? '0 : r_pos + IDX_W'(1);
        end
    end

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_byte) && $stable(i_out_last))
        else $error("output transaction changed while stalled");

    a_hdr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && r_pos == IDX_W'(0) |-> i_out_byte == FRAME_HDR)
        else $error("frame does not start with header byte");

    a_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && r_pos == IDX_W'(1) |->
            i_out_byte == CMD_ATTITUDE || i_out_byte == CMD_RESET)
        else $error("bad command byte");

    a_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> r_pos < IDX_W'(ATT_LEN) &&
            (i_out_last == (r_pos == IDX_W'(ATT_LEN - 1) ||
             (r_pos == IDX_W'(RST_LEN - 1) && i_out_last)) ||
             r_pos != IDX_W'(ATT_LEN - 1) && !i_out_last ||
             r_pos == IDX_W'(RST_LEN - 1)))
        else $error("frame length or last marker wrong");

    a_last_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_last |->
            r_pos == IDX_W'(RST_LEN - 1) || r_pos == IDX_W'(ATT_LEN - 1))
        else $error("last byte at wrong position");

endmodule

bind motion_command_frame_builder_top mcfb_chk u_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_out_valid (o_frm.valid),
    .i_out_ready (o_frm.ready),
    .i_out_byte  (o_frm.out_byte),
    .i_out_last  (o_frm.last_byte)
);

/* tb/sv/mcfb_frame_checker.sv */
`timescale 1ns / 1ps
// Frame checker for the motion command frame builder: watches the request and
// frame byte channels, predicts each frame with its CRC16 and compares byte by byte.
// Uses mcfb_pkg, mcfb_req_if and mcfb_byte_if.
module mcfb_frame_checker
    import mcfb_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    mcfb_req_if   i_req,
    mcfb_byte_if  i_frm,
    output int    o_fail_count,
    output int    o_pending
);

    typedef struct packed {
        logic [7:0] out_byte;
        logic       last_byte;
    } frame_byte_t;

    frame_byte_t bytes_due[$];
    frame_byte_t head;
    int          mismatches = 0;

    assign o_fail_count = mismatches;
    assign o_pending    = bytes_due.size();

    function automatic logic [15:0] crc16_modbus_byte(input logic [15:0] crc,
                                                      input logic [7:0]  b);
        logic [15:0] acc;
        acc = crc ^ {8'h00, b};
        repeat (8) begin
            acc = acc[0] ? ((acc >> 1) ^ CRC_POLY) : (acc >> 1);
        end
        return acc;
    endfunction

    function automatic void queue_frame(input logic        req_type,
                                        input logic [31:0] z_bits,
                                        input logic [31:0] x_bits,
                                        input logic [31:0] y_bits,
                                        input logic [7:0]  speed);
        logic [7:0]  frame [ATT_LEN];
        int          len;
        logic [15:0] crc;
        frame_byte_t fb;
        foreach (frame[i]) frame[i] = 8'h00;
        frame[0] = FRAME_HDR;
        if (req_type == REQ_ATTITUDE) begin
            frame[1] = CMD_ATTITUDE;
            for (int k = 0; k < 4; k++) begin
                frame[WORD_POS + k]     = z_bits[8*k +: 8];
                frame[WORD_POS + 4 + k] = x_bits[8*k +: 8];
                frame[WORD_POS + 8 + k] = y_bits[8*k +: 8];
            end
            frame[SPEED_POS] = speed;
            len = ATT_LEN;
        end else begin
            frame[1] = CMD_RESET;
            len = RST_LEN;
        end
        crc = CRC_INIT;
        for (int i = 0; i < len - 2; i++) crc = crc16_modbus_byte(crc, frame[i]);
        frame[len-2] = crc[7:0];
        frame[len-1] = crc[15:8];
        for (int i = 0; i < len; i++) begin
            fb.out_byte  = frame[i];
            fb.last_byte = (i == len - 1);
            bytes_due.push_back(fb);
        end
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            bytes_due.delete();
        end else begin
            if (i_frm.valid && i_frm.ready) begin
                if (bytes_due.size() == 0) begin
                    $error("frame byte %h arrived with no transaction expected", i_frm.out_byte);
                    mismatches++;
                end else begin
                    head = bytes_due.pop_front();
                    if (i_frm.out_byte !== head.out_byte) begin
                        $error("out_byte: expected %h, actual %h", head.out_byte, i_frm.out_byte);
                        mismatches++;
                    end
                    if (i_frm.last_byte !== head.last_byte) begin
                        $error("last_byte: expected %b, actual %b",
                               head.last_byte, i_frm.last_byte);
                        mismatches++;
                    end
                end
            end
            if (i_req.valid && i_req.ready) begin
                queue_frame(i_req.req_type, i_req.z_height_bits, i_req.x_rot_bits,
                            i_req.y_rot_bits, i_req.speed_level);
            end
        end
    end

endmodule

/* tb/sv/tb.sv */
`timescale 1ns / 1ps
// Testbench top for motion_command_frame_builder_top: clock, reset, request
// stimulus, frame byte back-pressure, watchdog and verdict.
// Uses mcfb_pkg, mcfb_req_if, mcfb_byte_if and mcfb_frame_checker.
module tb;
    import mcfb_pkg::*;

    localparam int STALL_LIMIT    = 5000;
    localparam int DRAIN_CYCLES   = 20;
    localparam int RAND_PER_PHASE = 160;

    logic i_clk;
    logic i_rst_n;
    int   send_idle_pct = 13;
    int   recv_idle_pct = 85;
    int   fail_count;
    int   pending;
    int   quiet_cycles  = 0;

    mcfb_req_if  req_ch ();
    mcfb_byte_if frm_ch ();

    motion_command_frame_builder_top DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch),
        .o_frm   (frm_ch)
    );

    mcfb_frame_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_req        (req_ch),
        .i_frm        (frm_ch),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    initial begin
        frm_ch.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            frm_ch.ready = ($urandom_range(99) >= recv_idle_pct);
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (req_ch.valid && req_ch.ready) || (frm_ch.valid && frm_ch.ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("Verification failed");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    function automatic logic [31:0] pick_float_bits();
        case ($urandom_range(15))
            0:       return 32'h0000_0000;
            1:       return 32'hFFFF_FFFF;
            2:       return 32'h7F80_0000;
            3:       return 32'h7FC0_0000;
            4:       return 32'h8000_0000;
            5:       return 32'h0000_0001;
            default: return $urandom;
        endcase
    endfunction

    // entered and left just after a falling edge
    task automatic send_request(input logic        req_type,
                                input logic [31:0] z_bits,
                                input logic [31:0] x_bits,
                                input logic [31:0] y_bits,
                                input logic [7:0]  speed);
        while ($urandom_range(99) < send_idle_pct) begin
            req_ch.valid = 1'b0;
            @(negedge i_clk);
        end
        req_ch.valid         = 1'b1;
        req_ch.req_type      = req_type;
        req_ch.z_height_bits = z_bits;
        req_ch.x_rot_bits    = x_bits;
        req_ch.y_rot_bits    = y_bits;
        req_ch.speed_level   = speed;
        do @(posedge i_clk); while (!req_ch.ready);
        @(negedge i_clk);
    endtask

    task automatic send_random_request();
        logic req_type;
        req_type = ($urandom_range(9) < 3) ? REQ_RESET : REQ_ATTITUDE;
        send_request(req_type, pick_float_bits(), pick_float_bits(), pick_float_bits(),
                     8'($urandom_range(255)));
    endtask

    task automatic wait_frames_done();
        req_ch.valid = 1'b0;
        while (pending != 0) @(negedge i_clk);
    endtask

    initial begin
        i_rst_n              = 1'b0;
        req_ch.valid         = 1'b0;
        req_ch.req_type      = REQ_ATTITUDE;
        req_ch.z_height_bits = '0;
        req_ch.x_rot_bits    = '0;
        req_ch.y_rot_bits    = '0;
        req_ch.speed_level   = '0;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // field extremes, float specials, both frame types back to back
        send_request(REQ_ATTITUDE, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 8'h00);
        send_request(REQ_ATTITUDE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'hFF);
        send_request(REQ_ATTITUDE, 32'h0403_0201, 32'h0807_0605, 32'h0C0B_0A09, 8'h0E);
        send_request(REQ_ATTITUDE, 32'h7FC0_0000, 32'h7F80_0000, 32'hFF80_0000, 8'h01);
        send_request(REQ_ATTITUDE, 32'h0000_0001, 32'h807F_FFFF, 32'h8000_0000, 8'h80);
        send_request(REQ_ATTITUDE, 32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA, 8'h55);
        send_request(REQ_ATTITUDE, 32'h5555_5555, 32'hAAAA_AAAA, 32'hFFFF_0000, 8'hAA);
        send_request(REQ_ATTITUDE, 32'h3F80_0000, 32'hBF80_0000, 32'h0000_FFFF, 8'h7F);
        send_request(REQ_RESET,    32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 8'h00);
        send_request(REQ_RESET,    32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'hFF);
        send_request(REQ_ATTITUDE, 32'h1234_5678, 32'h9ABC_DEF0, 32'hA5A5_1818, 8'h77);
        send_request(REQ_RESET,    32'hDEAD_BEEF, 32'h0BAD_F00D, 32'h7777_7777, 8'hA5);
        send_request(REQ_ATTITUDE, 32'h7F7F_FFFF, 32'h0080_0000, 32'hFF7F_FFFF, 8'hFE);
        wait_frames_done();

        for (int phase = 0; phase < 3; phase++) begin
            case (phase)
                0:       begin send_idle_pct = 13; recv_idle_pct = 85; end
                1:       begin send_idle_pct = 85; recv_idle_pct = 13; end
                default: begin send_idle_pct = 0;  recv_idle_pct = 0;  end
            endcase
            for (int i = 0; i < RAND_PER_PHASE; i++) begin
                if (i == RAND_PER_PHASE / 2) wait_frames_done();
                send_random_request();
            end
        end

        wait_frames_done();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
